>>> src/ftd_pkg.sv
// ftd_pkg: widths, reset values and helpers for frame_timestamp_decimator
// no dependencies

package ftd_pkg;

  localparam int TIME_W      = 63;
  localparam int DEADLINE_W  = 64;
  localparam int PERIOD_W    = 30;
  localparam int COUNT_W     = 32;
  localparam int TAG_W_DEF   = 8;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(33333333);

  localparam logic ACT_OFFER = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    logic [COUNT_W-1:0] r;
    r = (c == '1) ? c : c + COUNT_W'(1);
    return r;
  endfunction

endpackage

>>> src/frame_timestamp_decimator.sv
// frame_timestamp_decimator: keeps at most one frame group per output period
// depends on ftd_pkg
//
// usage:
// - input channel: in_valid / in_stall with action, group_tag, group_time,
//   group_complete; an item is taken when in_valid is high and in_stall low
// - output channel: out_valid / out_stall, one result item per input item,
//   holding the emitted group, flags and the four saturating counters
// - cfg_wr_en / cfg_wr_data write frame_period_ns (0 acts as 1); write only
//   while the block is idle
// - sequence: a taken clear goes to the done state and is then loaded into the
//   output register; an offered group passes the evaluate state and, once time
//   reaches the deadline, the pick state; at a full period or more past it, the
//   bit-serial remainder unit computes the new deadline one dividend bit per cycle
// - one item at a time: in_stall stays high from acceptance until the result
//   is loaded into the output register
// - a held result waits in the output register while out_stall is high; the
//   next item is still taken and parks at its end until the register frees
// - rst (synchronous) clears the control state, the counters and out_valid and
//   sets the period to 33333333 ns

module frame_timestamp_decimator
  import ftd_pkg::*;
#(
  parameter int TAG_WIDTH = TAG_W_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [PERIOD_W-1:0]  cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 action,
  input  logic [TAG_WIDTH-1:0] group_tag,
  input  logic [TIME_W-1:0]    group_time,
  input  logic                 group_complete,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 emit_valid,
  output logic [TAG_WIDTH-1:0] emit_tag,
  output logic [TIME_W-1:0]    emit_time,
  output logic                 input_rejected,
  output logic                 pending_held,
  output logic [COUNT_W-1:0]   inputs_seen,
  output logic [COUNT_W-1:0]   outputs_sent,
  output logic [COUNT_W-1:0]   groups_dropped,
  output logic [COUNT_W-1:0]   groups_invalid
);

  localparam int IDX_W = $clog2(DEADLINE_W);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_PICK = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]            state;
  logic [PERIOD_W-1:0]   period;

  logic [TAG_WIDTH-1:0]  cur_tag;
  logic [TIME_W-1:0]     cur_time;
  logic                  cur_ok;

  logic [DEADLINE_W-1:0] deadline;
  logic [TIME_W-1:0]     last_time;
  logic                  pend_valid;
  logic [TAG_WIDTH-1:0]  pend_tag;
  logic [TIME_W-1:0]     pend_time;
  logic [COUNT_W-1:0]    cnt_in;
  logic [COUNT_W-1:0]    cnt_out;
  logic [COUNT_W-1:0]    cnt_drop;
  logic [COUNT_W-1:0]    cnt_inv;

  logic                  res_emit;
  logic [TAG_WIDTH-1:0]  res_tag;
  logic [TIME_W-1:0]     res_time;
  logic                  res_rej;

  logic [DEADLINE_W-1:0] early_gap;
  logic [DEADLINE_W-1:0] after;
  logic [DEADLINE_W-1:0] div_num;
  logic [PERIOD_W-1:0]   rem;
  logic [IDX_W-1:0]      idx;

  logic [PERIOD_W-1:0]   p_eff;
  logic [DEADLINE_W-1:0] cur_time_x;
  logic [DEADLINE_W-1:0] pend_time_x;
  logic                  reject;
  logic [PERIOD_W:0]     rem_sh;
  logic                  rem_ge;
  logic                  take;
  logic                  out_free;

  assign p_eff       = (period == '0) ? PERIOD_W'(1) : period;
  assign cur_time_x  = {1'b0, cur_time};
  assign pend_time_x = {1'b0, pend_time};
  assign reject      = !cur_ok || (cur_time == '0) ||
                       ((last_time != '0) && (cur_time <= last_time));
  assign rem_sh      = {rem, div_num[DEADLINE_W-1]};
  assign rem_ge      = rem_sh >= {1'b0, p_eff};
  assign in_stall    = (state != ST_IDLE);
  assign take        = in_valid && !in_stall;
  assign out_free    = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_RESET;
    end else if (cfg_wr_en) begin
      period <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      deadline   <= '0;
      last_time  <= '0;
      pend_valid <= 1'b0;
      cnt_in     <= '0;
      cnt_out    <= '0;
      cnt_drop   <= '0;
      cnt_inv    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            cur_tag  <= group_tag;
            cur_time <= group_time;
            cur_ok   <= group_complete;
            res_emit <= 1'b0;
            res_tag  <= '0;
            res_time <= '0;
            res_rej  <= 1'b0;
            if (action == ACT_CLEAR) begin
              deadline   <= '0;
              last_time  <= '0;
              pend_valid <= 1'b0;
              cnt_in     <= '0;
              cnt_out    <= '0;
              cnt_drop   <= '0;
              cnt_inv    <= '0;
              state      <= ST_DONE;
            end else begin
              cnt_in <= sat_inc(cnt_in);
              state  <= ST_EVAL;
            end
          end
        end
        ST_EVAL: begin
          if (reject) begin
            res_rej  <= 1'b1;
            cnt_inv  <= sat_inc(cnt_inv);
            cnt_drop <= sat_inc(cnt_drop);
            state    <= ST_DONE;
          end else begin
            last_time <= cur_time;
            if (deadline == '0) begin
              deadline <= cur_time_x + DEADLINE_W'(p_eff);
              res_emit <= 1'b1;
              res_tag  <= cur_tag;
              res_time <= cur_time;
              cnt_out  <= sat_inc(cnt_out);
              state    <= ST_DONE;
            end else if (cur_time_x < deadline) begin
              if (pend_valid) begin
                cnt_drop <= sat_inc(cnt_drop);
              end
              pend_valid <= 1'b1;
              pend_tag   <= cur_tag;
              pend_time  <= cur_time;
              state      <= ST_DONE;
            end else begin
              res_emit  <= 1'b1;
              cnt_out   <= sat_inc(cnt_out);
              early_gap <= (deadline >= pend_time_x) ? deadline - pend_time_x : '0;
              after     <= cur_time_x - deadline;
              state     <= ST_PICK;
            end
          end
        end
        ST_PICK: begin
          // current group wins on a tie
          if (pend_valid && (after > early_gap)) begin
            res_tag   <= pend_tag;
            res_time  <= pend_time;
            pend_tag  <= cur_tag;
            pend_time <= cur_time;
          end else begin
            if (pend_valid) begin
              cnt_drop <= sat_inc(cnt_drop);
            end
            pend_valid <= 1'b0;
            res_tag    <= cur_tag;
            res_time   <= cur_time;
          end
          if (after < DEADLINE_W'(p_eff)) begin
            deadline <= deadline + DEADLINE_W'(p_eff);
            state    <= ST_DONE;
          end else begin
            div_num <= after;
            rem     <= '0;
            idx     <= '1;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          // one remainder bit per cycle
          rem     <= rem_ge ? PERIOD_W'(rem_sh - {1'b0, p_eff}) : rem_sh[PERIOD_W-1:0];
          div_num <= {div_num[DEADLINE_W-2:0], 1'b0};
          idx     <= idx - IDX_W'(1);
          if (idx == '0) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          deadline <= cur_time_x + DEADLINE_W'(p_eff - rem);
          state    <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      emit_valid     <= res_emit;
      emit_tag       <= res_tag;
      emit_time      <= res_time;
      input_rejected <= res_rej;
      pending_held   <= pend_valid;
      inputs_seen    <= cnt_in;
      outputs_sent   <= cnt_out;
      groups_dropped <= cnt_drop;
      groups_invalid <= cnt_inv;
    end
  end

`ifndef SYNTH
  a_pend_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && pend_valid) |-> (deadline != '0 && pend_time <= last_time))
    else $error("pending group without deadline or newer than last accepted");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV || state == ST_FIN) |-> (rem < p_eff))
    else $error("remainder not below period");

  a_load_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DONE))
    else $error("result loaded outside done state");

  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && emit_valid) |-> (outputs_sent != '0))
    else $error("emitted item without output count");
`endif

endmodule
